// ===== sv/prsm_pkg.sv =====
// Shared types, codes and helper functions of the PMP region slot manager.
package prsm_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_IN_USE  = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;

  // Command codes.
  localparam logic CMD_INSTALL   = 1'b0;
  localparam logic CMD_UNINSTALL = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PMP_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_POOL_BASE   = 2'd1;
  localparam logic [1:0] CFG_POOL_SIZE   = 2'd2;

  // PMP image constants.
  localparam logic [7:0] PMPCFG_NAPOT = 8'h18;
  localparam int unsigned IMAGE_CAP   = 16;
  localparam logic [4:0] PMP_ENTRIES_RESET = 5'd16;

  // What the output register is loaded with.
  typedef enum logic [1:0] {
    OUT_STATUS,
    OUT_SLOT,
    OUT_CLEAR
  } prsm_out_t;

  // One stored region slot.
  typedef struct packed {
    logic [2:0]  rights;
    logic [31:0] base;
    logic [31:0] size;
  } prsm_slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;
    logic       clr_walk;
    logic       inc_idx;
    logic       cnt_filled;
    logic       write_slot;
    logic       clear_slot;
    logic       load_out;
    prsm_out_t  out_kind;
    logic [2:0] out_code;
    logic       inc_k;
  } prsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_uninstall;
    logic bad_slot;
    logic bad_arg;
    logic slot_hit;
    logic pool_ovl;
    logic cur_used;
    logic slot_ovl;
    logic idx_last;
    logic limit;
    logic budget_zero;
    logic k_last;
    logic out_free;
  } prsm_stat_t;

  // Ranges overlap when both are non-empty; ends are taken at 33 bits.
  function automatic logic spans_intersect(input logic [31:0] a, input logic [31:0] as,
                                           input logic [31:0] b, input logic [31:0] bs);
    logic [32:0] a_end;
    logic [32:0] b_end;
    a_end = {1'b0, a} + {1'b0, as};
    b_end = {1'b0, b} + {1'b0, bs};
    return (as != 32'd0) && (bs != 32'd0) && ({1'b0, a} < b_end) && ({1'b0, b} < a_end);
  endfunction

  // A NAPOT block: power-of-two size of at least 8 and a base aligned to it.
  function automatic logic is_napot_block(input logic [31:0] base, input logic [31:0] size);
    logic [31:0] mask;
    mask = size - 32'd1;
    return (size >= 32'd8) && ((size & mask) == 32'd0) && ((base & mask) == 32'd0);
  endfunction

endpackage

// ===== sv/prsm_ctrl.sv =====
// Controller state machine that sequences checks, the slot walk and image output.
module prsm_ctrl
  import prsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  prsm_stat_t stat,
  output prsm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WREQ,
    S_WCMP,
    S_DECIDE,
    S_WRITE,
    S_EREQ,
    S_EOUT,
    S_FILL,
    S_STAT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] code_r, code_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.out_kind = OUT_STATUS;
    cmd.out_code = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_uninstall) begin
          if (stat.bad_slot) begin
            code_nxt  = ST_INVALID;
            state_nxt = S_STAT;
          end else if (!stat.slot_hit) begin
            code_nxt  = ST_OK;
            state_nxt = S_STAT;
          end else begin
            cmd.clear_slot = 1'b1;
            if (stat.budget_zero) begin
              code_nxt  = ST_OK;
              state_nxt = S_STAT;
            end else begin
              cmd.clr_walk = 1'b1;
              state_nxt    = S_EREQ;
            end
          end
        end else begin
          priority if (stat.bad_arg) begin
            code_nxt  = ST_INVALID;
            state_nxt = S_STAT;
          end else if (stat.slot_hit) begin
            code_nxt  = ST_IN_USE;
            state_nxt = S_STAT;
          end else if (stat.pool_ovl) begin
            code_nxt  = ST_OVERLAP;
            state_nxt = S_STAT;
          end else begin
            cmd.clr_walk = 1'b1;
            state_nxt    = S_WREQ;
          end
        end
      end
      // The slot memory read completes in this cycle.
      S_WREQ: begin
        state_nxt = S_WCMP;
      end
      S_WCMP: begin
        if (stat.cur_used && stat.slot_ovl) begin
          code_nxt  = ST_OVERLAP;
          state_nxt = S_STAT;
        end else begin
          cmd.cnt_filled = stat.cur_used;
          if (stat.idx_last) begin
            state_nxt = S_DECIDE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_WREQ;
          end
        end
      end
      S_DECIDE: begin
        if (stat.limit) begin
          code_nxt  = ST_LIMIT;
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_slot = 1'b1;
        if (stat.budget_zero) begin
          code_nxt  = ST_OK;
          state_nxt = S_STAT;
        end else begin
          cmd.clr_walk = 1'b1;
          state_nxt    = S_EREQ;
        end
      end
      S_EREQ: begin
        state_nxt = S_EOUT;
      end
      // Emit one filled slot as an image entry, or skip an empty slot.
      S_EOUT: begin
        if (stat.cur_used) begin
          if (stat.out_free) begin
            cmd.load_out = 1'b1;
            cmd.out_kind = OUT_SLOT;
            cmd.inc_k    = 1'b1;
            priority if (stat.k_last) begin
              state_nxt = S_IDLE;
            end else if (stat.idx_last) begin
              state_nxt = S_FILL;
            end else begin
              cmd.inc_idx = 1'b1;
              state_nxt   = S_EREQ;
            end
          end
        end else if (stat.idx_last) begin
          state_nxt = S_FILL;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_EREQ;
        end
      end
      // Cleared entries up to the budget.
      S_FILL: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_CLEAR;
          cmd.inc_k    = 1'b1;
          if (stat.k_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_STATUS;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered status code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== sv/prsm_datapath.sv =====
// Datapath: configuration, slot table memory, walk counters, checks and output register.
module prsm_datapath
  import prsm_pkg::*;
#(
  parameter int REGION_SLOTS    = 16,
  parameter int PMP_MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_command,
  input  logic [4:0]  in_slot_index,
  input  logic [31:0] in_region_base,
  input  logic [31:0] in_region_size,
  input  logic [2:0]  in_region_rights,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic        out_entry_valid,
  output logic [31:0] out_entry_addr,
  output logic [7:0]  out_entry_cfg,
  output logic        out_image_emitted,
  output logic        out_last,
  input  prsm_cmd_t   cmd,
  output prsm_stat_t  stat
);

  localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CNT_W  = $clog2(REGION_SLOTS + 1);
  localparam int CAP    = (PMP_MAX_ENTRIES < IMAGE_CAP) ? PMP_MAX_ENTRIES : IMAGE_CAP;
  localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

  // Configuration registers.
  logic [4:0]  pmp_entries_r;
  logic [31:0] pool_base_r;
  logic [31:0] pool_size_r;

  // Latched transaction.
  logic        cmd_r;
  logic [4:0]  slot_r;
  logic [31:0] base_r;
  logic [31:0] size_r;
  logic [2:0]  rights_r;

  // Slot table: used bits in flops, contents in a memory.
  logic [REGION_SLOTS-1:0] used_r;
  prsm_slot_t              mem [REGION_SLOTS];
  prsm_slot_t              rd_r;

  // Walk counters.
  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0]  filled_r;
  logic [4:0]        k_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r;
  logic [3:0]  index_r;
  logic        evalid_r;
  logic [31:0] addr_r;
  logic [7:0]  ecfg_r;
  logic        img_r;
  logic        last_r;

  logic [4:0]        budget;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_sel;
  logic              k_last;

  // Budget saturated to the entry count the hardware has.
  assign budget   = (pmp_entries_r > 5'(CAP)) ? 5'(CAP) : pmp_entries_r;
  assign slot_ok  = ({1'b0, slot_r} < 6'(REGION_SLOTS));
  assign slot_sel = slot_r[SLOT_W-1:0];
  assign k_last   = (5'(k_r + 5'd1) == budget);

  // Status toward the controller.
  always_comb begin
    stat.is_uninstall = (cmd_r == CMD_UNINSTALL);
    stat.bad_slot     = !slot_ok;
    stat.bad_arg      = !slot_ok || (rights_r == 3'd0) || !is_napot_block(base_r, size_r);
    stat.slot_hit     = slot_ok && used_r[slot_sel];
    stat.pool_ovl     = spans_intersect(base_r, size_r, pool_base_r, pool_size_r);
    stat.cur_used     = used_r[idx_r];
    stat.slot_ovl     = spans_intersect(base_r, size_r, rd_r.base, rd_r.size);
    stat.idx_last     = (idx_r == SLOT_W'(REGION_SLOTS - 1));
    stat.limit        = (CMP_W'(filled_r) >= CMP_W'(budget));
    stat.budget_zero  = (budget == 5'd0);
    stat.k_last       = k_last;
    stat.out_free     = !out_valid_r || out_ready;
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmp_entries_r <= PMP_ENTRIES_RESET;
      pool_base_r   <= 32'd0;
      pool_size_r   <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PMP_ENTRIES: pmp_entries_r <= cfg_data[4:0];
        CFG_POOL_BASE:   pool_base_r   <= cfg_data;
        CFG_POOL_SIZE:   pool_size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r    <= in_command;
      slot_r   <= in_slot_index;
      base_r   <= in_region_base;
      size_r   <= in_region_size;
      rights_r <= in_region_rights;
    end
  end

  // Used bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.write_slot) begin
      used_r[slot_sel] <= 1'b1;
    end else if (cmd.clear_slot) begin
      used_r[slot_sel] <= 1'b0;
    end
  end

  // Slot memory: one write port at the addressed slot, one registered read at the walk index.
  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      mem[slot_sel] <= '{rights: rights_r, base: base_r, size: size_r};
    end
    rd_r <= mem[idx_r];
  end

  // Walk index, filled count and image entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      filled_r <= '0;
      k_r      <= '0;
    end else if (cmd.clr_walk) begin
      idx_r    <= '0;
      filled_r <= '0;
      k_r      <= '0;
    end else begin
      if (cmd.inc_idx) begin
        idx_r <= SLOT_W'(idx_r + 1'b1);
      end
      if (cmd.cnt_filled) begin
        filled_r <= CNT_W'(filled_r + 1'b1);
      end
      if (cmd.inc_k) begin
        k_r <= 5'(k_r + 5'd1);
      end
    end
  end

  // Output register valid; a new result loads while the old one is taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.out_kind)
        OUT_SLOT: begin
          status_r <= ST_OK;
          index_r  <= k_r[3:0];
          evalid_r <= 1'b1;
          addr_r   <= (rd_r.base >> 2) | ((rd_r.size >> 3) - 32'd1);
          ecfg_r   <= PMPCFG_NAPOT | {5'd0, rd_r.rights};
          img_r    <= 1'b1;
          last_r   <= k_last;
        end
        OUT_CLEAR: begin
          status_r <= ST_OK;
          index_r  <= k_r[3:0];
          evalid_r <= 1'b0;
          addr_r   <= 32'd0;
          ecfg_r   <= 8'd0;
          img_r    <= 1'b1;
          last_r   <= k_last;
        end
        default: begin
          status_r <= cmd.out_code;
          index_r  <= 4'd0;
          evalid_r <= 1'b0;
          addr_r   <= 32'd0;
          ecfg_r   <= 8'd0;
          img_r    <= 1'b0;
          last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_entry_index   = index_r;
  assign out_entry_valid   = evalid_r;
  assign out_entry_addr    = addr_r;
  assign out_entry_cfg     = ecfg_r;
  assign out_image_emitted = img_r;
  assign out_last          = last_r;

endmodule

// ===== sv/pmp_region_slot_manager.sv =====
// Top level of the PMP region slot manager: controller and datapath.
//
// The block keeps REGION_SLOTS region slots and takes one install or uninstall
// transaction at a time; in_ready is high only while no transaction is being worked.
// A fault answers with a single status result. A successful change answers with
// the PMP image, one entry per result: the filled slots in slot order as NAPOT
// entries, then cleared entries, up to pmp_entries capped at PMP_MAX_ENTRIES and 16;
// with a budget of zero it answers with a single ok status instead. Each slot step
// has a request state and a compare or output state because the slot table is a
// memory with a registered read port. An install is captured, checked against the
// pool, walked over the slots for overlap, decided and written, and then answered
// with the image; an uninstall skips the walk. A stalled output holds the sequence.
// Configuration writes are always accepted and must only be issued while the block
// is idle.
module pmp_region_slot_manager
  import prsm_pkg::*;
#(
  parameter int REGION_SLOTS    = 16,
  parameter int PMP_MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [4:0]  in_slot_index,
  input  logic [31:0] in_region_base,
  input  logic [31:0] in_region_size,
  input  logic [2:0]  in_region_rights,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic        out_entry_valid,
  output logic [31:0] out_entry_addr,
  output logic [7:0]  out_entry_cfg,
  output logic        out_image_emitted,
  output logic        out_last
);

  prsm_cmd_t  cmd;
  prsm_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencing of each transaction.
  prsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, checks and result register.
  prsm_datapath #(
    .REGION_SLOTS    (REGION_SLOTS),
    .PMP_MAX_ENTRIES (PMP_MAX_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_slot_index     (in_slot_index),
    .in_region_base    (in_region_base),
    .in_region_size    (in_region_size),
    .in_region_rights  (in_region_rights),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_index   (out_entry_index),
    .out_entry_valid   (out_entry_valid),
    .out_entry_addr    (out_entry_addr),
    .out_entry_cfg     (out_entry_cfg),
    .out_image_emitted (out_image_emitted),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PMP region slot manager.
module testbench;
  import prsm_pkg::*;

  localparam int NSLOTS         = 16;
  localparam int PMP_MAX        = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 200;

  // One install or uninstall command as it enters the block.
  typedef struct packed {
    logic        command;
    logic [4:0]  slot;
    logic [31:0] base;
    logic [31:0] size;
    logic [2:0]  rights;
  } region_cmd_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_addr;
    logic [7:0]  entry_cfg;
    logic        image_emitted;
    logic        last;
  } pmp_result_t;

  // Predicts the slot table and the PMP image, and checks results against it.
  class region_image_scoreboard;
    logic [4:0]  entries_reg;
    logic [31:0] pool_base;
    logic [31:0] pool_size;
    bit          filled [NSLOTS];
    logic [2:0]  slot_rights [NSLOTS];
    logic [31:0] slot_base [NSLOTS];
    logic [31:0] slot_size [NSLOTS];
    pmp_result_t image_q [$];
    int          errors;

    function new();
      entries_reg = PMP_ENTRIES_RESET;
      pool_base   = 32'd0;
      pool_size   = 32'd0;
      errors      = 0;
      foreach (filled[i]) begin
        filled[i]      = 1'b0;
        slot_rights[i] = 3'd0;
        slot_base[i]   = 32'd0;
        slot_size[i]   = 32'd0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_PMP_ENTRIES: entries_reg = data[4:0];
        CFG_POOL_BASE:   pool_base = data;
        CFG_POOL_SIZE:   pool_size = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return image_q.size();
    endfunction

    // Image length: the register saturated to the hardware entry count and to 16.
    function int image_length();
      int n;
      n = int'(entries_reg);
      if (n > PMP_MAX) n = PMP_MAX;
      if (n > int'(IMAGE_CAP)) n = int'(IMAGE_CAP);
      return n;
    endfunction

    function bit is_napot(logic [31:0] b, logic [31:0] s);
      return (s >= 32'd8) && ((s & (s - 32'd1)) == 32'd0) && ((b & (s - 32'd1)) == 32'd0);
    endfunction

    // Range ends are formed at 33 bits so a range that ends at 2^32 does not wrap.
    function bit spans_meet(logic [31:0] a, logic [31:0] as, logic [31:0] b, logic [31:0] bs);
      logic [32:0] a_end;
      logic [32:0] b_end;
      a_end = {1'b0, a} + {1'b0, as};
      b_end = {1'b0, b} + {1'b0, bs};
      if (as == 32'd0 || bs == 32'd0) return 1'b0;
      return ({1'b0, a} < b_end) && ({1'b0, b} < a_end);
    endfunction

    function void push_status(logic [2:0] st);
      image_q.push_back('{st, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1});
    endfunction

    // Filled slots in slot order as NAPOT entries, then cleared entries; a zero length gives a bare ok status.
    function void emit_image();
      int n;
      int k;
      pmp_result_t r;
      n = image_length();
      k = 0;
      if (n == 0) begin
        push_status(ST_OK);
        return;
      end
      for (int i = 0; i < NSLOTS && k < n; i++) begin
        if (filled[i]) begin
          r.status        = ST_OK;
          r.entry_index   = 4'(k);
          r.entry_valid   = 1'b1;
          r.entry_addr    = (slot_base[i] >> 2) | ((slot_size[i] >> 3) - 32'd1);
          r.entry_cfg     = PMPCFG_NAPOT | {5'd0, slot_rights[i]};
          r.image_emitted = 1'b1;
          r.last          = (k + 1 == n);
          image_q.push_back(r);
          k++;
        end
      end
      for (; k < n; k++) begin
        image_q.push_back('{ST_OK, 4'(k), 1'b0, 32'd0, 8'd0, 1'b1, (k + 1 == n)});
      end
    endfunction

    // Applies one accepted command to the table and queues the results it causes.
    function void note_command(region_cmd_t c);
      int s;
      int used_count;
      s = int'(c.slot);
      used_count = 0;
      if (c.command == CMD_UNINSTALL) begin
        if (s >= NSLOTS) push_status(ST_INVALID);
        else if (!filled[s]) push_status(ST_OK);
        else begin
          filled[s]      = 1'b0;
          slot_rights[s] = 3'd0;
          slot_base[s]   = 32'd0;
          slot_size[s]   = 32'd0;
          emit_image();
        end
        return;
      end
      if (s >= NSLOTS || c.rights == 3'd0 || !is_napot(c.base, c.size)) begin
        push_status(ST_INVALID);
        return;
      end
      if (filled[s]) begin
        push_status(ST_IN_USE);
        return;
      end
      if (spans_meet(c.base, c.size, pool_base, pool_size)) begin
        push_status(ST_OVERLAP);
        return;
      end
      for (int i = 0; i < NSLOTS; i++) begin
        if (filled[i]) begin
          if (spans_meet(c.base, c.size, slot_base[i], slot_size[i])) begin
            push_status(ST_OVERLAP);
            return;
          end
          used_count++;
        end
      end
      if (used_count >= image_length()) begin
        push_status(ST_LIMIT);
        return;
      end
      filled[s]      = 1'b1;
      slot_rights[s] = c.rights;
      slot_base[s]   = c.base;
      slot_size[s]   = c.size;
      emit_image();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compares one accepted result with the oldest expected one.
    task check_result(pmp_result_t got);
      pmp_result_t want;
      if (image_q.size() == 0) begin
        report($sformatf("unexpected result, status %0d index %0d",
                         got.status, got.entry_index));
        return;
      end
      want = image_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.entry_index !== want.entry_index)
        report($sformatf("entry_index %0d, expected %0d", got.entry_index, want.entry_index));
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid %0d, expected %0d", got.entry_valid, want.entry_valid));
      if (got.entry_addr !== want.entry_addr)
        report($sformatf("entry_addr %h, expected %h", got.entry_addr, want.entry_addr));
      if (got.entry_cfg !== want.entry_cfg)
        report($sformatf("entry_cfg %h, expected %h", got.entry_cfg, want.entry_cfg));
      if (got.image_emitted !== want.image_emitted)
        report($sformatf("image_emitted %0d, expected %0d",
                         got.image_emitted, want.image_emitted));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PMP_ENTRIES;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_INSTALL;
  logic [4:0]  in_slot_index = 5'd0;
  logic [31:0] in_region_base = 32'd0;
  logic [31:0] in_region_size = 32'd0;
  logic [2:0]  in_region_rights = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_entry_index;
  logic        out_entry_valid;
  logic [31:0] out_entry_addr;
  logic [7:0]  out_entry_cfg;
  logic        out_image_emitted;
  logic        out_last;

  region_image_scoreboard sb;
  int items_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  pmp_region_slot_manager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_slot_index     (in_slot_index),
    .in_region_base    (in_region_base),
    .in_region_size    (in_region_size),
    .in_region_rights  (in_region_rights),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_entry_index   (out_entry_index),
    .out_entry_valid   (out_entry_valid),
    .out_entry_addr    (out_entry_addr),
    .out_entry_cfg     (out_entry_cfg),
    .out_image_emitted (out_image_emitted),
    .out_last          (out_last)
  );

  always #10 clk = ~clk;

  // Watchdog: ends the run when no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: checks each accepted transaction and throttles out_ready.
  // Once, it holds off for a long stretch so the block backs up into its input.
  initial begin : result_sink
    int hold_left;
    bit held;
    pmp_result_t got;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_status, out_entry_index, out_entry_valid, out_entry_addr,
               out_entry_cfg, out_image_emitted, out_last};
        sb.check_result(got);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && results_seen >= 600) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_ready <= (hold_left == 0) &&
                   ((results_seen >= 800 && results_seen < 1300) ||
                    $urandom_range(0, 99) >= 7);
    end
  end

  // Offers one command and waits until it is accepted; valid stays high afterward.
  task automatic send_cmd(input region_cmd_t c);
    if (!(items_sent >= 150 && items_sent < 250)) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_command       <= c.command;
    in_slot_index    <= c.slot;
    in_region_base   <= c.base;
    in_region_size   <= c.size;
    in_region_rights <= c.rights;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
    items_sent++;
  endtask

  task automatic install(input int slot, input logic [31:0] base, input logic [31:0] size,
                         input int rights);
    send_cmd('{CMD_INSTALL, 5'(slot), base, size, 3'(rights)});
  endtask

  // Base, size and rights are ignored by an uninstall, so they carry random content.
  task automatic uninstall(input int slot);
    send_cmd('{CMD_UNINSTALL, 5'(slot), $urandom(), $urandom(), 3'($urandom_range(0, 7))});
  endtask

  // Waits until the block is idle and every expected result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || !in_ready);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Writes all three registers back to back; only legal while the block is idle.
  task automatic write_cfg_set(input logic [4:0] entries, input logic [31:0] pbase,
                               input logic [31:0] psize);
    cfg_put(CFG_PMP_ENTRIES, {27'd0, entries});
    cfg_put(CFG_POOL_BASE, pbase);
    cfg_put(CFG_POOL_SIZE, psize);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed installs and uninstalls, some aimed at filled slots or
  // at the pool, and a share of random noise.
  function automatic region_cmd_t random_cmd();
    region_cmd_t c;
    int pick;
    int lg;
    int s;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, NSLOTS - 1);
    lg = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 31) : $urandom_range(3, 20);
    c.command = CMD_INSTALL;
    c.slot    = 5'(s);
    c.size    = 32'd1 << lg;
    c.base    = $urandom() & ~(c.size - 32'd1);
    c.rights  = 3'($urandom_range(1, 7));
    if (pick < 35) begin
      c.command = CMD_UNINSTALL;
      if ($urandom_range(0, 9) == 0) c.slot = 5'($urandom_range(NSLOTS, 31));
    end else if (pick < 45) begin
      // An aligned block around a filled slot's base always overlaps it.
      if (sb.filled[s]) c.base = sb.slot_base[s] & ~(c.size - 32'd1);
      c.slot = 5'($urandom_range(0, NSLOTS - 1));
    end else if (pick < 53) begin
      c.base = sb.pool_base & ~(c.size - 32'd1);
    end else if (pick < 65) begin
      c.command = 1'($urandom_range(0, 1));
      c.slot    = 5'($urandom_range(0, 31));
      c.base    = $urandom();
      c.rights  = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: c.size = $urandom();
        1: c.size = 32'($urandom_range(0, 15));
        2: c.size = c.size | (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic run_phase(input logic [4:0] entries, input logic [31:0] pbase,
                           input logic [31:0] psize, input int count);
    settle();
    write_cfg_set(entries, pbase, psize);
    repeat (count) send_cmd(random_cmd());
  endtask

  // Stimulus: reset, directed cases, random phases over several settings.
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Argument faults, slot in use, pool and slot overlap, a region ending at 2^32.
    write_cfg_set(5'd16, 32'h8000_0000, 32'h0000_1000);
    install(0, 32'h0000_0000, 32'd8, 7);
    install(0, 32'h0000_0100, 32'h100, 3);
    install(16, 32'h0000_0100, 32'h100, 3);
    install(31, 32'h0000_0100, 32'h100, 3);
    install(1, 32'h0000_0100, 32'h100, 0);
    install(1, 32'h0000_0100, 32'd12, 1);
    install(1, 32'h0000_0000, 32'd4, 1);
    install(1, 32'h0000_0010, 32'h20, 1);
    install(1, 32'h0000_0000, 32'd0, 1);
    install(1, 32'h8000_0800, 32'h800, 1);
    install(1, 32'h7FFF_F000, 32'h1000, 6);
    install(2, 32'h0000_0000, 32'd16, 1);
    install(15, 32'hFFFF_FFF8, 32'd8, 1);
    install(3, 32'hC000_0000, 32'h4000_0000, 5);
    uninstall(20);
    uninstall(5);
    uninstall(15);
    install(4, 32'h0000_1000, 32'h1000, 2);

    // Budget below the filled count, then the largest region.
    settle();
    write_cfg_set(5'd2, 32'd0, 32'd0);
    install(6, 32'h0000_2000, 32'h1000, 3);
    uninstall(0);
    uninstall(1);
    install(7, 32'h8000_0000, 32'h8000_0000, 4);

    // Empty budget: installs hit the limit, uninstalls give a bare ok.
    settle();
    write_cfg_set(5'd0, 32'd0, 32'd0);
    install(8, 32'h0001_0000, 32'h100, 7);
    uninstall(7);
    uninstall(4);

    run_phase(5'd4,  32'h4000_0000, 32'h0100_0000, 100);
    run_phase(5'd0,  32'h0000_0000, 32'h0000_0000, 40);
    run_phase(5'd31, 32'hFFFF_F000, 32'h0000_1000, 100);
    run_phase(5'd1,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
    run_phase(5'd16, 32'h0000_0000, 32'hFFFF_FFFF, 30);
    run_phase(5'd8,  32'h2000_0000, 32'h1000_0000, 90);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/prsm_pkg.sv
sv/prsm_ctrl.sv
sv/prsm_datapath.sv
sv/pmp_region_slot_manager.sv
tb/testbench.sv
